// File: hdl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

    localparam int LEAD_SPAN   = 50;
    localparam int TRAIL_SPAN  = 49;
    localparam int SAMPLE_BITS = 24;

    localparam int WINDOW    = LEAD_SPAN + TRAIL_SPAN + 1;
    localparam int PTR_BITS  = $clog2(WINDOW);
    localparam int CNT_BITS  = $clog2(WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int D_BITS    = $clog2(TRAIL_SPAN + 1);

    // divider retires this many quotient bits per clock
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_CYCLES     = (SUM_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_PAD        = DIV_CYCLES * DIV_RADIX_BITS;
    localparam int STEP_BITS      = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic take;         // input transfer: capture item, read slot at write pointer
        logic add;          // enter sample into window
        logic read_oldest;  // read slot of the oldest windowed sample
        logic drop;         // remove oldest sample from the sum
        logic div_start;
        logic out_load;
        logic next_out;     // one fewer flush output pending
        logic clear_row;
    } cbs_cmd_t;

    typedef struct packed {
        logic last;         // item in work carries the row end mark
        logic emit_ok;      // enough samples seen for a streaming output
        logic trim;         // window still holds a sample too far back
        logic div_last;     // divider finishes this cycle
        logic out_free;
        logic row_done;     // result now in the divider ends the row
    } cbs_sts_t;

endpackage

`default_nettype wire

// File: hdl/cbs_in_if.sv
`default_nettype none

interface cbs_in_if import cbs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   row_last;

    modport source (output valid, output sample, output row_last, input ready);
    modport sink   (input valid, input sample, input row_last, output ready);
endinterface

`default_nettype wire

// File: hdl/cbs_out_if.sv
`default_nettype none

interface cbs_out_if import cbs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] smoothed;
    logic                   row_end;

    modport source (output valid, output smoothed, output row_end, input ready);
    modport sink   (input valid, input smoothed, input row_end, output ready);
endinterface

`default_nettype wire

// File: hdl/cbs_div.sv
`default_nettype none

module cbs_div import cbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [SUM_BITS-1:0]    dividend,
    input  wire logic [CNT_BITS-1:0]    divisor,
    output logic                        last_step,
    output logic [SAMPLE_BITS-1:0]      quotient
);

    logic                  busy_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [CNT_BITS-1:0]   rem_reg;
    logic [CNT_BITS-1:0]   rem_next;
    logic [DIV_PAD-1:0]    quo_reg;
    logic [DIV_PAD-1:0]    quo_next;
    logic [CNT_BITS-1:0]   div_reg;
    logic [CNT_BITS:0]     trial;

    // restoring division; dividend shifts out of the top while quotient bits enter below
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            trial    = {rem_next, quo_next[DIV_PAD-1]};
            quo_next = {quo_next[DIV_PAD-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next    = CNT_BITS'(trial - {1'b0, div_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[CNT_BITS-1:0];
            end
        end
    end

    assign last_step = busy_reg && (step_reg == STEP_BITS'(DIV_CYCLES - 1));
    assign quotient  = quo_reg[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= DIV_PAD'(dividend);
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/cbs_datapath.sv
`default_nettype none

module cbs_datapath import cbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cbs_cmd_t               cmd,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   row_last,
    input  wire logic                   out_ready,
    output cbs_sts_t                    sts,
    output logic                        out_valid,
    output logic [SAMPLE_BITS-1:0]      smoothed,
    output logic                        row_end
);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rdata_reg;
    logic [PTR_BITS-1:0]    raddr;

    logic [SAMPLE_BITS-1:0] x_reg;
    logic                   last_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [PTR_BITS-1:0]    wr_reg;
    logic [PTR_BITS-1:0]    rd_reg;     // oldest sample in the window
    logic [CNT_BITS-1:0]    pos_reg;    // samples seen, saturating at the window size
    logic [CNT_BITS-1:0]    cnt_reg;    // samples now in the window
    logic [D_BITS-1:0]      d_reg;      // flush outputs left after the current one
    logic                   end_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;
    logic                   out_end_reg;

    logic                   full;
    logic [CNT_BITS-1:0]    pos_inc;
    logic [D_BITS-1:0]      d_init;
    logic [SUM_BITS-1:0]    sum_add;
    logic [CNT_BITS-1:0]    need_cap;
    logic [CNT_BITS-1:0]    need;
    logic                   div_last;
    logic [SAMPLE_BITS-1:0] quotient;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(WINDOW - 1)) ? '0 : p + 1'b1;
    endfunction

    cbs_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (sum_reg),
        .divisor   (cnt_reg),
        .last_step (div_last),
        .quotient  (quotient)
    );

    assign raddr = cmd.read_oldest ? rd_reg : wr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            mem[wr_reg] <= x_reg;
        end
        if (cmd.take || cmd.read_oldest)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        full     = (pos_reg == CNT_BITS'(WINDOW));
        pos_inc  = full ? pos_reg : pos_reg + 1'b1;
        d_init   = (pos_inc > CNT_BITS'(TRAIL_SPAN)) ? D_BITS'(TRAIL_SPAN)
                                                     : D_BITS'(pos_inc - 1'b1);
        sum_add  = sum_reg - (full ? SUM_BITS'(rdata_reg) : '0) + SUM_BITS'(x_reg);
        need_cap = CNT_BITS'(d_reg) + CNT_BITS'(LEAD_SPAN + 1);
        need     = (pos_reg < need_cap) ? pos_reg : need_cap;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
            sum_reg  <= '0;
            wr_reg   <= '0;
            rd_reg   <= '0;
            pos_reg  <= '0;
            cnt_reg  <= '0;
            d_reg    <= '0;
            end_reg  <= 1'b0;
        end
        else if (cmd.clear_row)
        begin
            last_reg <= 1'b0;
            sum_reg  <= '0;
            wr_reg   <= '0;
            rd_reg   <= '0;
            pos_reg  <= '0;
            cnt_reg  <= '0;
            d_reg    <= '0;
            end_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                last_reg <= row_last;
            end
            if (cmd.add)
            begin
                sum_reg <= sum_add;
                wr_reg  <= ptr_inc(wr_reg);
                if (full)
                begin
                    rd_reg <= ptr_inc(rd_reg);
                end
                pos_reg <= pos_inc;
                cnt_reg <= pos_inc;
                if (last_reg)
                begin
                    d_reg <= d_init;
                end
            end
            if (cmd.drop)
            begin
                sum_reg <= sum_reg - SUM_BITS'(rdata_reg);
                cnt_reg <= cnt_reg - 1'b1;
                rd_reg  <= ptr_inc(rd_reg);
            end
            if (cmd.next_out)
            begin
                d_reg <= d_reg - 1'b1;
            end
            if (cmd.div_start)
            begin
                end_reg <= last_reg && (d_reg == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= quotient;
            out_end_reg  <= end_reg;
        end
    end

    always_comb
    begin
        sts.last     = last_reg;
        sts.emit_ok  = (pos_reg > CNT_BITS'(TRAIL_SPAN));
        sts.trim     = (cnt_reg > need);
        sts.div_last = div_last;
        sts.out_free = !out_valid_reg || out_ready;
        sts.row_done = end_reg;
    end

    assign out_valid = out_valid_reg;
    assign smoothed  = out_data_reg;
    assign row_end   = out_end_reg;

endmodule

`default_nettype wire

// File: hdl/cbs_ctrl.sv
`default_nettype none

module cbs_ctrl import cbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire cbs_sts_t sts,
    output logic          in_ready,
    output cbs_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADD  = 6'b000010,
        S_TRIM = 6'b000100,
        S_DROP = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } cbs_state_t;

    cbs_state_t state_reg;
    cbs_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_TRIM;
            end
            S_TRIM:
            begin
                if (sts.last)
                begin
                    if (sts.trim)
                    begin
                        cmd.read_oldest = 1'b1;
                        state_next      = S_DROP;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else if (sts.emit_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_TRIM;
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.row_done)
                    begin
                        cmd.clear_row = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else if (sts.last)
                    begin
                        cmd.next_out = 1'b1;
                        state_next   = S_TRIM;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/centered_boxcar_smoother_unit.sv
// channel  dir  payload                    transfer
// in_ch    in   sample[23:0], row_last     valid && ready
// out_ch   out  smoothed[23:0], row_end    valid && ready
//
// A sample that yields no result (first 49 of a row) passes through accept, window
// update and trim check; one that yields a result passes through accept, window
// update, divider start, the divider steps at 4 quotient bits per clock and output load.
// Each further flush output after the row's last sample passes through the trim check,
// the divider steps and output load, plus a read and a drop for every sample dropped.
// rst_n clears the row state; the delay line needs no clearing.
// A stalled output holds the sequencer in its output state until the transfer.

`default_nettype none

module centered_boxcar_smoother_unit import cbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbs_in_if.sink    in_ch,
    cbs_out_if.source out_ch
);

    cbs_cmd_t cmd;
    cbs_sts_t sts;
    logic     in_ready;

    cbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    cbs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (in_ch.sample),
        .row_last  (in_ch.row_last),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .out_valid (out_ch.valid),
        .smoothed  (out_ch.smoothed),
        .row_end   (out_ch.row_end)
    );

    assign in_ch.ready = in_ready;

endmodule

`default_nettype wire
